// ===== hdl/mms_pkg.sv =====
// Shared types and constants for the modulation mode sequencer.
// Holds the microcode formats, the sequencer/datapath interface structs and widths.
// No dependencies.
package mms_pkg;

	localparam int DWELL_BITS      = 32;
	localparam int BLEND_FRAC_BITS = 16;
	localparam int BLEND_W         = BLEND_FRAC_BITS + 1;
	localparam int FREQ_W          = 16;
	localparam int STEP_W          = 16;
	localparam int CFG_W           = 16;
	localparam int MS_TO_US        = 1000;
	// milliseconds scaled to microseconds
	localparam int THR_W           = CFG_W + $clog2(MS_TO_US);
	localparam int CMP_W           = (DWELL_BITS > THR_W) ? DWELL_BITS : THR_W;
	localparam int NUM_W           = STEP_W + BLEND_FRAC_BITS;
	localparam int QUO_W           = BLEND_FRAC_BITS + 1;
	localparam int HI_W            = NUM_W - QUO_W;
	localparam int REM_W           = THR_W + 1;
	localparam int QCNT_W          = $clog2(QUO_W + 1);
	localparam int UA_W            = 4;
	localparam int IN_TDATA_W      = 40;
	localparam int OUT_TDATA_W     = 24;

	localparam logic [BLEND_W-1:0] BLEND_ONE = BLEND_W'(1) << BLEND_FRAC_BITS;

	typedef enum logic [1:0] {
		REG_ENTER_FREQ = 2'd0,
		REG_EXIT_FREQ  = 2'd1,
		REG_MIN_DWELL  = 2'd2,
		REG_FADE       = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_CLEAR,
		OP_STEADY,
		OP_ARM,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_INC,
		OP_RAMP,
		OP_HARD,
		OP_COMMIT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_DISABLED,
		COND_PENDING,
		COND_FADE_ZERO,
		COND_DIV_MORE
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [UA_W-1:0] target;
		logic            last;
	} ucode_t;

	typedef struct packed {
		logic exec;
		op_t  op;
	} mms_ctrl_t;

	typedef struct packed {
		logic disabled;
		logic pending;
		logic fade_zero;
		logic div_more;
	} mms_status_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

endpackage

// ===== hdl/modulation_mode_sequencer.sv =====
// Top level of the modulation mode sequencer: stream ports, config registers, output register.
// Depends on mms_pkg, mms_sequencer and mms_datapath.
//
//  Channel   Signals                                   Carries
//  s_axis    s_axis_tvalid/tready/tdata[39:0]          one control tick per item
//  m_axis    m_axis_tvalid/tready/tdata[23:0]          one mode/blend result per tick
//  cfg       cfg_we, cfg_index[1:0], cfg_data[15:0]    thresholds, dwell and fade times
//
// Each item runs a steady update, a clear when disabled or the step is zero, a
// crossfade ramp (the restoring divider for the ramp step retires one quotient bit
// per cycle, 17 bits), or a hard switch. The result is registered in the cycle after
// the final step, and the next item is accepted in that same cycle. Reset clears all
// mode state and loads the register defaults. A stalled output holds the sequencer on
// its final step; a new item is accepted only while the sequencer is idle, even if a
// result still waits.
module modulation_mode_sequencer import mms_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [0] enable, [16:1] step_us, [32:17] elec_freq, [39:33] zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [0] mode, [1] source_mode, [2] target_mode, [19:3] blend,
	// [20] transition_active, [23:21] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	// configuration; times are kept in microseconds
	logic signed [FREQ_W-1:0] enter_freq_q;
	logic signed [FREQ_W-1:0] exit_freq_q;
	logic [THR_W-1:0]         min_dwell_us_q;
	logic [THR_W-1:0]         fade_us_q;
	logic [THR_W-1:0]         cfg_us;

	// captured input item
	logic                     enable_q;
	logic [STEP_W-1:0]        step_us_q;
	logic signed [FREQ_W-1:0] elec_freq_q;

	logic                     out_valid_q;
	logic [OUT_TDATA_W-1:0]   out_data_q;
	logic                     done_s1;

	mms_ctrl_t                ctrl;
	mms_status_t              status;
	logic                     seq_idle;
	logic                     seq_done;
	logic                     in_take;

	logic                     mode;
	logic                     source_mode;
	logic                     target_mode;
	logic [BLEND_W-1:0]       blend;
	logic                     transition_active;

	assign cfg_us = THR_W'(cfg_data) * THR_W'(MS_TO_US);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_freq_q   <= FREQ_W'(32767);
			exit_freq_q    <= '0;
			min_dwell_us_q <= '0;
			fade_us_q      <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ENTER_FREQ: enter_freq_q   <= cfg_data;
				REG_EXIT_FREQ:  exit_freq_q    <= cfg_data;
				REG_MIN_DWELL:  min_dwell_us_q <= cfg_us;
				REG_FADE:       fade_us_q      <= cfg_us;
				default: begin
				end
			endcase
		end
	end

	assign s_axis_tready = seq_idle;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	// latch the tick fields; they stay put while the program runs
	always_ff @(posedge clk) begin
		if (in_take) begin
			enable_q    <= s_axis_tdata[0];
			step_us_q   <= s_axis_tdata[STEP_W:1];
			elec_freq_q <= s_axis_tdata[STEP_W+FREQ_W:STEP_W+1];
		end
	end

	mms_sequencer u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_take),
		.out_busy(out_valid_q && !m_axis_tready),
		.status  (status),
		.ctrl    (ctrl),
		.idle    (seq_idle),
		.done    (seq_done)
	);

	mms_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctrl             (ctrl),
		.status           (status),
		.enable           (enable_q),
		.step_us          (step_us_q),
		.elec_freq        (elec_freq_q),
		.enter_freq       (enter_freq_q),
		.exit_freq        (exit_freq_q),
		.min_dwell_us     (min_dwell_us_q),
		.fade_us          (fade_us_q),
		.mode             (mode),
		.source_mode      (source_mode),
		.target_mode      (target_mode),
		.blend            (blend),
		.transition_active(transition_active)
	);

	// the final step writes the datapath at the same edge; capture in the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= seq_done;
		end
	end

	// output register: drop valid once taken, load once the program's writes have landed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1) begin
			out_data_q <= OUT_TDATA_W'({transition_active, blend, target_mode,
				source_mode, mode});
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== hdl/mms_divider.sv =====
// Restoring divider, one quotient bit per cycle while step_en is high, for the blend ramp step.
// Depends on mms_pkg for widths.
module mms_divider import mms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              init,
	input  logic              step_en,
	input  logic [HI_W-1:0]   dividend_hi,
	input  logic [QUO_W-1:0]  dividend_lo,
	input  logic [THR_W-1:0]  divisor,
	output logic [QUO_W-1:0]  quotient,
	output logic              rem_nz,
	output logic              more
);

	logic [REM_W-1:0]  rem_q;
	logic [QUO_W-1:0]  lo_q;
	logic [QUO_W-1:0]  quo_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [REM_W-1:0]  trial;
	logic              fits;

	// shift in the next dividend bit, then try the subtract
	assign trial = {rem_q[REM_W-2:0], lo_q[QUO_W-1]};
	assign fits  = trial >= REM_W'(divisor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (init) begin
			cnt_q <= QCNT_W'(QUO_W);
		end else if (step_en) begin
			cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (init) begin
			rem_q <= REM_W'(dividend_hi);
			lo_q  <= dividend_lo;
			quo_q <= '0;
		end else if (step_en) begin
			rem_q <= fits ? (trial - REM_W'(divisor)) : trial;
			lo_q  <= {lo_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign rem_nz   = rem_q != '0;
	assign more     = cnt_q != QCNT_W'(1);

endmodule

// ===== hdl/mms_datapath.sv =====
// Datapath of the mode sequencer: mode state, dwell counter, blend level.
// Executes one micro-op per cycle while ctrl.exec is high; depends on mms_pkg and mms_divider.
module mms_datapath import mms_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mms_ctrl_t                 ctrl,
	output mms_status_t               status,
	input  logic                      enable,
	input  logic [STEP_W-1:0]         step_us,
	input  logic signed [FREQ_W-1:0]  elec_freq,
	input  logic signed [FREQ_W-1:0]  enter_freq,
	input  logic signed [FREQ_W-1:0]  exit_freq,
	input  logic [THR_W-1:0]          min_dwell_us,
	input  logic [THR_W-1:0]          fade_us,
	output logic                      mode,
	output logic                      source_mode,
	output logic                      target_mode,
	output logic [BLEND_W-1:0]        blend,
	output logic                      transition_active
);

	logic                  cur_q, from_q, to_q, pending_q, active_q, sat_q;
	logic [DWELL_BITS-1:0] dwell_q;
	logic [BLEND_W-1:0]    blend_q;
	logic [BLEND_W-1:0]    inc_q;

	logic [NUM_W-1:0]      num;
	logic [HI_W-1:0]       num_hi;
	logic [QUO_W-1:0]      quo;
	logic                  rem_nz;
	logic                  div_more;
	logic [DWELL_BITS:0]   dwell_sum;
	logic [DWELL_BITS-1:0] dwell_sat;
	logic                  seek;
	logic [QUO_W:0]        inc_raw;
	logic [BLEND_W:0]      blend_up;
	logic [BLEND_W-1:0]    mode_blend;
	logic                  op_en;

	assign op_en  = ctrl.exec;
	assign num    = {step_us, {BLEND_FRAC_BITS{1'b0}}};
	assign num_hi = num[NUM_W-1:QUO_W];

	mms_divider u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.init       (op_en && ctrl.op == OP_DIV_INIT),
		.step_en    (op_en && ctrl.op == OP_DIV_STEP),
		.dividend_hi(num_hi),
		.dividend_lo(num[QUO_W-1:0]),
		.divisor    (fade_us),
		.quotient   (quo),
		.rem_nz     (rem_nz),
		.more       (div_more)
	);

	assign dwell_sum  = {1'b0, dwell_q} + (DWELL_BITS+1)'(step_us);
	assign dwell_sat  = dwell_sum[DWELL_BITS] ? '1 : dwell_sum[DWELL_BITS-1:0];
	assign seek       = cur_q ? (elec_freq <= exit_freq) : (elec_freq >= enter_freq);
	assign inc_raw    = {1'b0, quo} + (QUO_W+1)'(rem_nz);
	assign blend_up   = {1'b0, blend_q} + {1'b0, inc_q};
	assign mode_blend = cur_q ? BLEND_ONE : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= 1'b0;
			from_q    <= 1'b0;
			to_q      <= 1'b0;
			pending_q <= 1'b0;
			active_q  <= 1'b0;
			dwell_q   <= '0;
			blend_q   <= '0;
		end else if (op_en) begin
			case (ctrl.op)
				OP_CLEAR: begin
					cur_q     <= 1'b0;
					from_q    <= 1'b0;
					to_q      <= 1'b0;
					pending_q <= 1'b0;
					active_q  <= 1'b0;
					dwell_q   <= '0;
					blend_q   <= '0;
				end
				OP_STEADY: begin
					from_q   <= cur_q;
					to_q     <= cur_q;
					active_q <= 1'b0;
					blend_q  <= mode_blend;
					dwell_q  <= seek ? dwell_sat : '0;
				end
				OP_ARM: begin
					if (CMP_W'(dwell_q) >= CMP_W'(min_dwell_us)) begin
						dwell_q   <= '0;
						pending_q <= 1'b1;
						to_q      <= ~cur_q;
					end
				end
				OP_RAMP: begin
					if (to_q && !from_q) begin
						if (blend_up >= (BLEND_W+1)'(BLEND_ONE)) begin
							blend_q   <= BLEND_ONE;
							pending_q <= 1'b0;
						end else begin
							blend_q <= blend_up[BLEND_W-1:0];
						end
					end else if (blend_q <= inc_q) begin
						blend_q   <= '0;
						pending_q <= 1'b0;
					end else begin
						blend_q <= blend_q - inc_q;
					end
				end
				OP_HARD: begin
					blend_q   <= to_q ? BLEND_ONE : '0;
					pending_q <= 1'b0;
				end
				OP_COMMIT: begin
					if (!pending_q) begin
						cur_q  <= to_q;
						from_q <= to_q;
					end
					active_q <= pending_q;
				end
				default: begin
				end
			endcase
		end
	end

	// ramp step scratch registers
	always_ff @(posedge clk) begin
		if (op_en && ctrl.op == OP_DIV_INIT) begin
			sat_q <= REM_W'(num_hi) >= REM_W'(fade_us);
		end
		if (op_en && ctrl.op == OP_INC) begin
			if (sat_q || inc_raw > (QUO_W+1)'(BLEND_ONE)) begin
				inc_q <= BLEND_ONE;
			end else begin
				inc_q <= inc_raw[BLEND_W-1:0];
			end
		end
	end

	assign status.disabled  = !enable || step_us == '0;
	assign status.pending   = pending_q;
	assign status.fade_zero = fade_us == '0;
	assign status.div_more  = div_more;

	assign mode              = cur_q;
	assign source_mode       = from_q;
	assign target_mode       = to_q;
	assign blend             = blend_q;
	assign transition_active = active_q;

endmodule

// ===== hdl/mms_sequencer.sv =====
// Microcode sequencer: step counter, control store and jump logic.
// Depends on mms_pkg for the control word and interface structs.
module mms_sequencer import mms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        out_busy,
	input  mms_status_t status,
	output mms_ctrl_t   ctrl,
	output logic        idle,
	output logic        done
);

	localparam logic [UA_W-1:0] UA_ENTRY  = UA_W'(0);
	localparam logic [UA_W-1:0] UA_CHK    = UA_W'(1);
	localparam logic [UA_W-1:0] UA_STEADY = UA_W'(2);
	localparam logic [UA_W-1:0] UA_ARM    = UA_W'(3);
	localparam logic [UA_W-1:0] UA_CLEAR  = UA_W'(4);
	localparam logic [UA_W-1:0] UA_RAMP   = UA_W'(5);
	localparam logic [UA_W-1:0] UA_DINIT  = UA_W'(6);
	localparam logic [UA_W-1:0] UA_DSTEP  = UA_W'(7);
	localparam logic [UA_W-1:0] UA_INC    = UA_W'(8);
	localparam logic [UA_W-1:0] UA_APPLY  = UA_W'(9);
	localparam logic [UA_W-1:0] UA_COMMIT = UA_W'(10);
	localparam logic [UA_W-1:0] UA_HARD   = UA_W'(11);

	function automatic ucode_t rom_word(input logic [UA_W-1:0] a);
		ucode_t w;
		w = '{op: OP_NOP, cond: COND_NEVER, target: UA_ENTRY, last: 1'b1};
		case (a)
			UA_ENTRY:  w = '{op: OP_NOP,      cond: COND_DISABLED,  target: UA_CLEAR,  last: 1'b0};
			UA_CHK:    w = '{op: OP_NOP,      cond: COND_PENDING,   target: UA_RAMP,   last: 1'b0};
			UA_STEADY: w = '{op: OP_STEADY,   cond: COND_NEVER,     target: UA_ENTRY,  last: 1'b0};
			UA_ARM:    w = '{op: OP_ARM,      cond: COND_NEVER,     target: UA_ENTRY,  last: 1'b1};
			UA_CLEAR:  w = '{op: OP_CLEAR,    cond: COND_NEVER,     target: UA_ENTRY,  last: 1'b1};
			UA_RAMP:   w = '{op: OP_NOP,      cond: COND_FADE_ZERO, target: UA_HARD,   last: 1'b0};
			UA_DINIT:  w = '{op: OP_DIV_INIT, cond: COND_NEVER,     target: UA_ENTRY,  last: 1'b0};
			UA_DSTEP:  w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE,  target: UA_DSTEP,  last: 1'b0};
			UA_INC:    w = '{op: OP_INC,      cond: COND_NEVER,     target: UA_ENTRY,  last: 1'b0};
			UA_APPLY:  w = '{op: OP_RAMP,     cond: COND_NEVER,     target: UA_ENTRY,  last: 1'b0};
			UA_COMMIT: w = '{op: OP_COMMIT,   cond: COND_NEVER,     target: UA_ENTRY,  last: 1'b1};
			UA_HARD:   w = '{op: OP_HARD,     cond: COND_ALWAYS,    target: UA_COMMIT, last: 1'b0};
			default:   w = '{op: OP_NOP,      cond: COND_NEVER,     target: UA_ENTRY,  last: 1'b1};
		endcase
		return w;
	endfunction

	seq_state_t      state_q, state_d;
	logic [UA_W-1:0] pc_q, pc_d;
	ucode_t          word;
	logic            exec;
	logic            take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			pc_q    <= UA_ENTRY;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
		end
	end

	always_comb begin
		word    = rom_word(pc_q);
		state_d = state_q;
		pc_d    = pc_q;
		exec    = 1'b0;
		take    = 1'b0;
		case (word.cond)
			COND_ALWAYS:    take = 1'b1;
			COND_DISABLED:  take = status.disabled;
			COND_PENDING:   take = status.pending;
			COND_FADE_ZERO: take = status.fade_zero;
			COND_DIV_MORE:  take = status.div_more;
			default:        take = 1'b0;
		endcase
		case (state_q)
			SEQ_IDLE: begin
				if (start) begin
					state_d = SEQ_RUN;
					pc_d    = UA_ENTRY;
				end
			end
			SEQ_RUN: begin
				// hold the final step until the output register is free
				exec = !(word.last && out_busy);
				if (exec) begin
					if (word.last) begin
						state_d = SEQ_IDLE;
						pc_d    = UA_ENTRY;
					end else begin
						pc_d = take ? word.target : pc_q + UA_W'(1);
					end
				end
			end
			default: begin
				state_d = SEQ_IDLE;
				pc_d    = UA_ENTRY;
			end
		endcase
	end

	assign ctrl.exec = exec;
	assign ctrl.op   = word.op;
	assign idle      = state_q == SEQ_IDLE;
	assign done      = exec && word.last;

endmodule
